/* rtl/core/brf_pkg.sv */
package brf_pkg;

    localparam logic [1:0] KIND_QUERY     = 2'd0;
    localparam logic [1:0] KIND_WR_ALLOW  = 2'd1;
    localparam logic [1:0] KIND_WR_DENY   = 2'd2;
    localparam logic [1:0] KIND_RESERVED  = 2'd3;

    localparam logic [7:0] FAMILY_ANY     = 8'd0;
    localparam logic [7:0] FAMILY_INET    = 8'd2;
    localparam logic [7:0] FAMILY_INET6   = 8'd10;

    localparam logic [1:0] BY_FAMILY      = 2'd0;
    localparam logic [1:0] BY_ALLOW_RULE  = 2'd1;
    localparam logic [1:0] BY_DENY_RULE   = 2'd2;
    localparam logic [1:0] BY_NO_MATCH    = 2'd3;

    localparam logic       CFG_ALLOW_COUNT = 1'b0;
    localparam logic       CFG_DENY_COUNT  = 1'b1;

    typedef enum logic [1:0] {
        OP_QUERY,
        OP_WR_ALLOW,
        OP_WR_DENY
    } t_op_code;

    typedef struct packed {
        logic [1:0]  kind;
        logic [6:0]  rule_index;
        logic        hook_v6;
        logic [7:0]  addr_family;
        logic [7:0]  sock_family;
        logic [7:0]  proto;
        logic [15:0] port_value;
        logic [15:0] port_count;
    } t_in_item;

    typedef struct packed {
        logic        verdict;
        logic [1:0]  decided_by;
    } t_out_item;

    // Classified operation handed from the front to the back.
    typedef struct packed {
        t_op_code    op;
        logic        mismatch;
        logic [6:0]  index;
        logic [7:0]  family;
        logic [7:0]  proto;
        logic [15:0] port;
        logic [15:0] span;
    } t_op;

    typedef struct packed {
        logic [7:0]  allow_count;
        logic [7:0]  deny_count;
    } t_cfg;

endpackage

/* rtl/core/brf_front.sv */
module brf_front
    import brf_pkg::*;
(
    input  logic     i_in_valid,
    input  t_in_item i_in_item,
    input  logic     i_q_full,
    output logic     o_in_ready,
    output logic     o_push,
    output t_op      o_op
);

    logic       push_ok;
    logic [7:0] want;

    always_comb begin
        want    = i_in_item.hook_v6 ? FAMILY_INET6 : FAMILY_INET;
        push_ok = 1'b1;
        o_op.op = OP_QUERY;
        case (i_in_item.kind)
            KIND_QUERY:    o_op.op = OP_QUERY;
            KIND_WR_ALLOW: o_op.op = OP_WR_ALLOW;
            KIND_WR_DENY:  o_op.op = OP_WR_DENY;
            default:       push_ok = 1'b0;
        endcase
        o_op.mismatch = (i_in_item.addr_family != want) || (i_in_item.sock_family != want);
        o_op.index    = i_in_item.rule_index;
        o_op.family   = i_in_item.addr_family;
        o_op.proto    = i_in_item.proto;
        // Queries carry the port in network byte order; rules hold host order.
        o_op.port     = (i_in_item.kind == KIND_QUERY)
                      ? {i_in_item.port_value[7:0], i_in_item.port_value[15:8]}
                      : i_in_item.port_value;
        o_op.span     = i_in_item.port_count;
    end

    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full && push_ok;

endmodule

/* rtl/core/brf_queue.sv */
module brf_queue
    import brf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    output logic o_full,
    output logic o_valid,
    output t_op  o_op,
    input  logic i_pop
);

    t_op        r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    logic do_pop;

    assign do_pop  = i_pop && (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_op    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_mem[r_wr_ptr] <= i_op;
                r_wr_ptr        <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* rtl/core/brf_back.sv */
module brf_back
    import brf_pkg::*;
#(
    parameter int MAX_RULES            = 128,
    parameter int MATCH_NOTHING_FAMILY = 255
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_op_valid,
    input  t_op       i_op,
    output logic      o_op_ready,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int AW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int CW = $clog2(MAX_RULES + 1);

    typedef struct packed {
        logic [7:0]  family;
        logic [7:0]  proto;
        logic [15:0] low;
        logic [15:0] span;
    } t_rule;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESULT
    } t_state;

    t_rule mem_allow [MAX_RULES];
    t_rule mem_deny  [MAX_RULES];
    t_rule r_rd_allow;
    t_rule r_rd_deny;

    t_state      r_state;
    logic        r_phase;
    logic [CW-1:0] r_addr;
    logic        r_rd_vld;
    logic [7:0]  r_fam;
    logic [7:0]  r_proto;
    logic [15:0] r_port;
    t_out_item   r_res;
    logic        r_out_valid;
    t_out_item   r_out_item;

    logic [CW-1:0] lim_a;
    logic [CW-1:0] lim_d;
    logic [CW-1:0] cur_lim;
    logic          issue;
    logic          hit;
    logic          idx_ok;
    logic          take;
    logic          emit;
    t_rule         cur_rule;
    t_rule         wr_rule;

    function automatic logic rule_hits(t_rule r, logic [7:0] fam, logic [7:0] prot,
                                       logic [15:0] port);
        logic [16:0] upper;
        logic        ok;
        upper = {1'b0, r.low} + {1'b0, r.span};
        ok    = 1'b1;
        if (r.family == 8'(MATCH_NOTHING_FAMILY)) begin
            ok = 1'b0;
        end else if ((r.family != FAMILY_ANY) && (r.family != fam)) begin
            ok = 1'b0;
        end else if ((r.proto != 8'd0) && (r.proto != prot)) begin
            ok = 1'b0;
        end else if (r.span != 16'd0) begin
            ok = (port >= r.low) && ({1'b0, port} < upper);
        end
        return ok;
    endfunction

    // Counts above the table depth are taken as the full table.
    assign lim_a = (32'(i_cfg.allow_count) > MAX_RULES) ? CW'(MAX_RULES)
                                                       : CW'(i_cfg.allow_count);
    assign lim_d = (32'(i_cfg.deny_count) > MAX_RULES) ? CW'(MAX_RULES)
                                                      : CW'(i_cfg.deny_count);

    assign cur_lim  = r_phase ? lim_d : lim_a;
    assign issue    = (r_state == S_SCAN) && (r_addr < cur_lim);
    assign cur_rule = r_phase ? r_rd_deny : r_rd_allow;
    assign hit      = r_rd_vld && rule_hits(cur_rule, r_fam, r_proto, r_port);
    assign idx_ok   = 32'(i_op.index) < MAX_RULES;
    assign take     = (r_state == S_IDLE) && i_op_valid;
    assign emit     = (r_state == S_RESULT) && (!r_out_valid || i_out_ready);
    assign wr_rule  = '{family: i_op.family, proto: i_op.proto, low: i_op.port,
                        span: i_op.span};

    assign o_op_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (take && (i_op.op == OP_WR_ALLOW) && idx_ok) begin
            mem_allow[AW'(i_op.index)] <= wr_rule;
        end
        if (take && (i_op.op == OP_WR_DENY) && idx_ok) begin
            mem_deny[AW'(i_op.index)] <= wr_rule;
        end
        if (issue) begin
            r_rd_allow <= mem_allow[r_addr[AW-1:0]];
            r_rd_deny  <= mem_deny[r_addr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= 1'b0;
            r_addr      <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_op_valid && (i_op.op == OP_QUERY)) begin
                        r_fam   <= i_op.family;
                        r_proto <= i_op.proto;
                        r_port  <= i_op.port;
                        r_phase <= 1'b0;
                        r_addr  <= '0;
                        r_rd_vld <= 1'b0;
                        if (i_op.mismatch) begin
                            r_res   <= '{verdict: 1'b1, decided_by: BY_FAMILY};
                            r_state <= S_RESULT;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (hit) begin
                        r_res    <= r_phase
                                  ? t_out_item'{verdict: 1'b0, decided_by: BY_DENY_RULE}
                                  : t_out_item'{verdict: 1'b1, decided_by: BY_ALLOW_RULE};
                        r_rd_vld <= 1'b0;
                        r_state  <= S_RESULT;
                    end else if (issue) begin
                        r_addr   <= r_addr + CW'(1);
                        r_rd_vld <= 1'b1;
                    end else begin
                        // Table exhausted and the last read, if any, missed.
                        r_rd_vld <= 1'b0;
                        r_addr   <= '0;
                        if (!r_phase) begin
                            r_phase <= 1'b1;
                        end else begin
                            r_res   <= '{verdict: 1'b1, decided_by: BY_NO_MATCH};
                            r_state <= S_RESULT;
                        end
                    end
                end
                S_RESULT: begin
                    if (emit) begin
                        r_out_item  <= r_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* rtl/core/bind_rule_filter_unit.sv */
// Channel   Direction  Handshake                 Payload
// in        input      i_in_valid / o_in_ready   i_in_item  (t_in_item)
// out       output     o_out_valid / i_out_ready o_out_item (t_out_item)
// cfg       input      i_cfg_we                  i_cfg_idx, i_cfg_data
//
// A rule write is stored in its table when the back end takes it from the queue;
// a query whose families do not match the hook goes to its result without a scan.
// Any other query scans the allow table and then the deny table, one entry per
// cycle through the registered table read port; each count is limited to
// MAX_RULES and the scan stops at the first hit. Reset is synchronous and active
// low; tables hold no reset value. A two-entry queue separates intake from the
// scan, so up to two transactions are still taken while a result waits for the
// output side.
module bind_rule_filter_unit
    import brf_pkg::*;
#(
    parameter int MAX_RULES            = 128,
    parameter int MATCH_NOTHING_FAMILY = 255
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item,
    input  logic      i_cfg_we,
    input  logic      i_cfg_idx,
    input  logic [7:0] i_cfg_data
);

    t_cfg r_cfg;
    logic q_push;
    logic q_full;
    logic q_valid;
    logic q_pop;
    t_op  front_op;
    t_op  q_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ALLOW_COUNT: r_cfg.allow_count <= i_cfg_data;
                CFG_DENY_COUNT:  r_cfg.deny_count  <= i_cfg_data;
                default:         r_cfg <= r_cfg;
            endcase
        end
    end

    brf_front u_front (
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .i_q_full   (q_full),
        .o_in_ready (o_in_ready),
        .o_push     (q_push),
        .o_op       (front_op)
    );

    brf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (front_op),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_op    (q_op),
        .i_pop   (q_pop)
    );

    brf_back #(
        .MAX_RULES            (MAX_RULES),
        .MATCH_NOTHING_FAMILY (MATCH_NOTHING_FAMILY)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_op_valid  (q_valid),
        .i_op        (q_op),
        .o_op_ready  (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("queue written while full");

    a_reserved_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && (i_in_item.kind == KIND_RESERVED)) |-> !q_push)
        else $error("reserved kind entered the queue");

    a_deny_only_by_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.decided_by != BY_DENY_RULE)) |-> o_out_item.verdict)
        else $error("deny verdict without a deny rule");

endmodule

/* bench/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import brf_pkg::*;

    localparam int         MAX_RULES    = 128;
    localparam logic [7:0] NEVER_FAMILY = 8'd255;
    localparam int         QUIET_LIMIT  = 5000;
    localparam int         SETTLE       = 16;
    localparam int         TAIL         = 300;
    localparam int         HOLD_CYCLES  = 400;

    typedef struct packed {
        logic [7:0]  family;
        logic [7:0]  proto;
        logic [15:0] low_port;
        logic [15:0] span;
    } t_acl_rule;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    t_in_item   in_item   = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_out_item  out_item;
    logic       cfg_we    = 1'b0;
    logic       cfg_idx   = CFG_ALLOW_COUNT;
    logic [7:0] cfg_data  = '0;

    // Shadow copy of the rule tables and counts.
    t_acl_rule  allow_tbl [MAX_RULES];
    t_acl_rule  deny_tbl  [MAX_RULES];
    logic [7:0] allow_used = '0;
    logic [7:0] deny_used  = '0;

    t_out_item  verdict_q [$];
    int         mismatches     = 0;
    int         quiet_cycles   = 0;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    int         hold_left      = 0;

    bind_rule_filter_unit #(
        .MAX_RULES           (MAX_RULES),
        .MATCH_NOTHING_FAMILY(NEVER_FAMILY)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    function automatic bit rule_hits(t_acl_rule r, logic [7:0] fam, logic [7:0] prot,
                                     logic [15:0] port);
        if (r.family == NEVER_FAMILY) return 1'b0;
        if (r.family != FAMILY_ANY && r.family != fam) return 1'b0;
        if (r.proto != 8'd0 && r.proto != prot) return 1'b0;
        if (r.span == 16'd0) return 1'b1;
        // The upper bound is computed wide so that a range never wraps.
        return (int'(port) >= int'(r.low_port)) &&
               (int'(port) < int'(r.low_port) + int'(r.span));
    endfunction

    function automatic bit table_hits(bit deny_side, logic [7:0] fam, logic [7:0] prot,
                                      logic [15:0] port);
        int n;
        n = deny_side ? deny_used : allow_used;
        if (n > MAX_RULES) n = MAX_RULES;
        for (int i = 0; i < n; i++) begin
            if (rule_hits(deny_side ? deny_tbl[i] : allow_tbl[i], fam, prot, port)) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_out_item bind_verdict(t_in_item q);
        logic [7:0]  want;
        logic [15:0] port;
        t_out_item   r;
        want = q.hook_v6 ? FAMILY_INET6 : FAMILY_INET;
        port = {q.port_value[7:0], q.port_value[15:8]};
        if (q.addr_family != want || q.sock_family != want) begin
            r = '{verdict: 1'b1, decided_by: BY_FAMILY};
        end else if (table_hits(1'b0, q.addr_family, q.proto, port)) begin
            r = '{verdict: 1'b1, decided_by: BY_ALLOW_RULE};
        end else if (table_hits(1'b1, q.addr_family, q.proto, port)) begin
            r = '{verdict: 1'b0, decided_by: BY_DENY_RULE};
        end else begin
            r = '{verdict: 1'b1, decided_by: BY_NO_MATCH};
        end
        return r;
    endfunction

    function automatic void absorb_item(t_in_item it);
        t_acl_rule r;
        r = '{family: it.addr_family, proto: it.proto, low_port: it.port_value,
              span: it.port_count};
        case (it.kind)
            KIND_QUERY:    verdict_q.push_back(bind_verdict(it));
            KIND_WR_ALLOW: allow_tbl[it.rule_index] = r;
            KIND_WR_DENY:  deny_tbl[it.rule_index] = r;
            default: ;
        endcase
    endfunction

    function automatic void check_result(t_out_item got);
        t_out_item want;
        if (verdict_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: verdict %0d decided_by %0d",
                         got.verdict, got.decided_by);
            return;
        end
        want = verdict_q.pop_front();
        if (got.verdict !== want.verdict || got.decided_by !== want.decided_by) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result mismatch: expected verdict %0d decided_by %0d, got %0d %0d",
                         want.verdict, want.decided_by, got.verdict, got.decided_by);
        end
    endfunction

    // Both channels are sampled at the falling edge; the TB only drives at the
    // rising edge, so these values are the ones seen at the next rising edge.
    always @(negedge clk) begin
        bit active;
        active = 1'b0;
        if (rst_n) begin
            if (in_valid && in_ready) begin
                absorb_item(in_item);
                active = 1'b1;
            end
            if (out_valid && out_ready) begin
                check_result(out_item);
                active = 1'b1;
            end
            if (cfg_we) active = 1'b1;
            quiet_cycles = active ? 0 : quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    always @(posedge clk) begin
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left--;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic t_in_item rule_item(logic [1:0] kind, logic [6:0] idx,
                                           logic [7:0] fam, logic [7:0] prot,
                                           logic [15:0] low, logic [15:0] span);
        t_in_item it;
        it = '0;
        it.kind        = kind;
        it.rule_index  = idx;
        it.addr_family = fam;
        it.proto       = prot;
        it.port_value  = low;
        it.port_count  = span;
        return it;
    endfunction

    function automatic t_in_item query_item(bit v6, logic [7:0] prot, logic [15:0] host_port);
        t_in_item it;
        it = '0;
        it.kind        = KIND_QUERY;
        it.hook_v6     = v6;
        it.addr_family = v6 ? FAMILY_INET6 : FAMILY_INET;
        it.sock_family = it.addr_family;
        it.proto       = prot;
        it.port_value  = {host_port[7:0], host_port[15:8]};
        return it;
    endfunction

    function automatic t_in_item random_rule(logic [1:0] kind, logic [6:0] idx);
        t_in_item it;
        int pick;
        it.kind        = kind;
        it.rule_index  = idx;
        it.hook_v6     = 1'($urandom_range(1));
        it.sock_family = 8'($urandom);
        pick = $urandom_range(9);
        it.addr_family = (pick < 2) ? FAMILY_ANY : (pick < 4) ? FAMILY_INET :
                         (pick < 6) ? FAMILY_INET6 : (pick == 6) ? NEVER_FAMILY : 8'($urandom);
        pick = $urandom_range(9);
        it.proto = (pick < 2) ? 8'd0 : (pick < 5) ? 8'd6 : (pick < 8) ? 8'd17 : 8'($urandom);
        pick = $urandom_range(3);
        it.port_value = (pick == 0) ? 16'($urandom_range(1023)) :
                        (pick == 1) ? 16'(65535 - $urandom_range(300)) : 16'($urandom);
        pick = $urandom_range(7);
        case (pick)
            0:       it.port_count = 16'd0;
            1, 2, 3: it.port_count = 16'($urandom_range(64, 1));
            4:       it.port_count = 16'hFFFF;
            5:       it.port_count = 16'($urandom);
            default: it.port_count = 16'($urandom_range(4096, 1));
        endcase
        return it;
    endfunction

    // Most queries pass the family check and aim at or just beside a rule in use.
    function automatic t_in_item random_query();
        t_in_item    it;
        t_acl_rule   aim;
        logic [7:0]  want;
        logic [15:0] port;
        int          pick;
        int          n;
        bit          deny_side;
        it.kind       = KIND_QUERY;
        it.rule_index = 7'($urandom);
        it.hook_v6    = 1'($urandom_range(1));
        it.port_count = 16'($urandom);
        want = it.hook_v6 ? FAMILY_INET6 : FAMILY_INET;
        it.addr_family = want;
        it.sock_family = want;
        pick = $urandom_range(19);
        if (pick == 0) it.addr_family = 8'($urandom);
        else if (pick == 1) it.sock_family = 8'($urandom);
        else if (pick == 2) it.addr_family = it.hook_v6 ? FAMILY_INET : FAMILY_INET6;
        else if (pick == 3) it.sock_family = it.hook_v6 ? FAMILY_INET : FAMILY_INET6;
        pick = $urandom_range(9);
        it.proto = (pick < 2) ? 8'd0 : (pick < 5) ? 8'd6 : (pick < 8) ? 8'd17 : 8'($urandom);
        port = 16'($urandom);
        deny_side = 1'($urandom_range(1));
        n = deny_side ? deny_used : allow_used;
        if (n > MAX_RULES) n = MAX_RULES;
        if (n > 0 && $urandom_range(3) != 0) begin
            aim = deny_side ? deny_tbl[$urandom_range(n - 1)] : allow_tbl[$urandom_range(n - 1)];
            if (aim.proto != 8'd0 && $urandom_range(4) != 0) it.proto = aim.proto;
            case ($urandom_range(4))
                0:       port = aim.low_port;
                1:       port = aim.low_port + aim.span - 16'd1;
                2:       port = aim.low_port + aim.span;
                3:       port = aim.low_port - 16'd1;
                default: port = aim.low_port + 16'($urandom_range(aim.span));
            endcase
        end
        it.port_value = {port[7:0], port[15:8]};
        return it;
    endfunction

    function automatic t_in_item noise_item();
        t_in_item it;
        it = random_query();
        it.kind = KIND_RESERVED;
        return it;
    endfunction

    function automatic logic [7:0] random_count();
        int pick;
        pick = $urandom_range(9);
        if (pick < 6) return 8'($urandom_range(12));
        if (pick < 9) return 8'($urandom_range(MAX_RULES));
        return 8'(MAX_RULES);
    endfunction

    // Called and returning at a rising edge. On return the transaction has just
    // been taken and valid is still high; the caller either sends again or
    // lowers valid in the same step.
    task automatic send_item(t_in_item it);
        bit hit;
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do begin
            @(negedge clk);
            hit = in_ready;
            @(posedge clk);
        end while (!hit);
    endtask

    // Stops the input and waits until every expected result has come, then
    // lets a rule write still in the back end finish.
    task automatic quiesce();
        in_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_counts(logic [7:0] allow_n, logic [7:0] deny_n);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_ALLOW_COUNT;
        cfg_data <= allow_n;
        @(posedge clk);
        cfg_idx  <= CFG_DENY_COUNT;
        cfg_data <= deny_n;
        @(posedge clk);
        cfg_we   <= 1'b0;
        @(posedge clk);
        allow_used = allow_n;
        deny_used  = deny_n;
    endtask

    task automatic run_mix(int items);
        int pick;
        for (int k = 0; k < items; k++) begin
            pick = $urandom_range(99);
            if (pick < 70)
                send_item(random_query());
            else if (pick < 95)
                send_item(random_rule($urandom_range(1) ? KIND_WR_DENY : KIND_WR_ALLOW,
                                      7'($urandom)));
            else
                send_item(noise_item());
        end
    endtask

    task automatic test_directed();
        t_in_item it;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // Both counts are zero here, so a family-matched query gets the default allow.
        send_item(query_item(1'b0, 8'd6, 16'd80));
        send_item(query_item(1'b1, 8'hFF, 16'hFFFF));
        it = query_item(1'b1, 8'd0, 16'd0);
        it.sock_family = FAMILY_INET;
        send_item(it);
        it.sock_family = FAMILY_INET6;
        it.addr_family = NEVER_FAMILY;
        send_item(it);
        it = query_item(1'b0, 8'd17, 16'd53);
        it.addr_family = FAMILY_INET6;
        it.sock_family = FAMILY_INET6;
        send_item(it);
        it.kind = KIND_RESERVED;
        send_item(it);
        send_item(rule_item(KIND_WR_ALLOW, 7'd0, FAMILY_INET, 8'd6, 16'd80, 16'd1));
        send_item(rule_item(KIND_WR_ALLOW, 7'd1, FAMILY_INET6, 8'd0, 16'hFFF0, 16'hFFFF));
        send_item(rule_item(KIND_WR_DENY, 7'd0, NEVER_FAMILY, 8'd0, 16'd0, 16'd0));
        send_item(rule_item(KIND_WR_DENY, 7'd1, FAMILY_ANY, 8'd0, 16'd0, 16'd0));
        quiesce();
        set_counts(8'd2, 8'd2);
        send_item(query_item(1'b0, 8'd6, 16'd80));
        send_item(query_item(1'b0, 8'd6, 16'd81));
        send_item(query_item(1'b0, 8'd17, 16'd80));
        // The range starting near the top of the port space must not wrap to zero.
        send_item(query_item(1'b1, 8'd99, 16'hFFFF));
        send_item(query_item(1'b1, 8'd0, 16'hFFF0));
        send_item(query_item(1'b1, 8'd0, 16'h0005));
        send_item(query_item(1'b1, 8'd0, 16'hFFEF));
        quiesce();
        set_counts(8'd0, 8'd2);
        send_item(query_item(1'b0, 8'd6, 16'd80));
        quiesce();
        // The only deny rule left in use is the one that matches nothing.
        set_counts(8'd2, 8'd1);
        send_item(query_item(1'b0, 8'd17, 16'd80));
        quiesce();
    endtask

    task automatic test_load_tables();
        send_idle_pct  = 26;
        recv_stall_pct = 26;
        for (int i = 0; i < MAX_RULES; i++) begin
            send_item(random_rule(KIND_WR_ALLOW, 7'(i)));
            send_item(random_rule(KIND_WR_DENY, 7'(i)));
        end
        quiesce();
    endtask

    task automatic test_count_extremes();
        logic [7:0] allow_n [5] = '{8'd128, 8'd255, 8'd129, 8'd0, 8'd128};
        logic [7:0] deny_n  [5] = '{8'd128, 8'd200, 8'd0, 8'd255, 8'd0};
        send_idle_pct  = 26;
        recv_stall_pct = 26;
        for (int s = 0; s < 5; s++) begin
            set_counts(allow_n[s], deny_n[s]);
            for (int k = 0; k < 10; k++) send_item(random_query());
            quiesce();
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_counts(8'd24, 8'd24);
        @(negedge clk);
        hold_left = HOLD_CYCLES;
        @(posedge clk);
        for (int k = 0; k < 16; k++) send_item(random_query());
        quiesce();
    endtask

    task automatic test_random_phases();
        int idle_pct  [4] = '{0, 81, 0, 26};
        int stall_pct [4] = '{0, 0, 81, 26};
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = idle_pct[p];
            recv_stall_pct = stall_pct[p];
            for (int seg = 0; seg < 5; seg++) begin
                set_counts(random_count(), random_count());
                run_mix(50);
                quiesce();
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_load_tables();
        test_count_extremes();
        test_backpressure();
        test_random_phases();
        quiesce();
        repeat (TAIL) @(posedge clk);
        if (mismatches == 0 && verdict_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
